/* rtl/sorted_window_trimmed_mean_top_assert.svh */
`ifndef SORTED_WINDOW_TRIMMED_MEAN_TOP_ASSERT_SVH
`define SORTED_WINDOW_TRIMMED_MEAN_TOP_ASSERT_SVH

// same-cycle implication, disabled while dis is high
`define SWTM_ASSERT_IMPLY(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("swtm assertion failed");

// next-cycle implication, disabled while dis is high
`define SWTM_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("swtm assertion failed");

`endif

/* rtl/swtm_pkg.sv */
package swtm_pkg;

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int TDATA_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = SAMPLE_W + 2;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;

    // default sizes
    localparam int SAMPLE_COUNT_DEF = 16;
    localparam int FIFO_DEPTH_DEF   = 4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q16     = 2'd1;

    // 0.80855 in unsigned q0.16, truncated
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd52989;

    // queue entry between front and back
    typedef struct packed {
        logic                last;
        logic [SAMPLE_W-1:0] sample;
    } entry_t;

endpackage

/* rtl/sorted_window_trimmed_mean_top.sv */
// channel   dir  tdata fields (low bit up)      notes
// s_        in   sample[11:0], [15:12] ignored  one converter reading per word
// m_        out  filtered_value[11:0], zero pad one word per completed block
// cfg_      in   index 0 scale_enable, 1 gain   write only, no read-back
//
// each sample is inserted into the sorted block store, shifting every stored
// entry larger than it up one slot (one read and one write per cycle); the
// closing sample then reads the four middle entries, averages them, applies
// the gain multiply and loads m_.
// aresetn is synchronous; the block store needs no clearing after reset.
// a result waiting on m_tready stalls only the next block's end, and the
// input queue keeps s_tready high while the sorter is busy until it fills.
module sorted_window_trimmed_mean_top #(
    parameter int SAMPLE_COUNT = swtm_pkg::SAMPLE_COUNT_DEF,
    parameter int FIFO_DEPTH   = swtm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [swtm_pkg::TDATA_W-1:0]     s_tdata,   // [11:0] sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [swtm_pkg::TDATA_W-1:0]     m_tdata,   // [11:0] filtered_value
    input  logic                             cfg_wen,
    input  logic [swtm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swtm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic                        scale_enable_reg;
    logic [swtm_pkg::GAIN_W-1:0] gain_q16_reg;
    logic                        push;
    swtm_pkg::entry_t            push_entry;
    logic                        q_ready;
    logic                        pop;
    swtm_pkg::entry_t            pop_entry;
    logic                        q_valid;

    // configuration registers, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_enable_reg <= 1'b0;
            gain_q16_reg     <= swtm_pkg::GAIN_RESET;
        end else if (cfg_wen) begin
            if (cfg_index == swtm_pkg::REG_SCALE_ENABLE) begin
                scale_enable_reg <= cfg_wdata[0];
            end else if (cfg_index == swtm_pkg::REG_GAIN_Q16) begin
                gain_q16_reg <= cfg_wdata[swtm_pkg::GAIN_W-1:0];
            end
        end
    end

    // block position tagging
    swtm_front #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready)
    );

    // decoupling queue
    swtm_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_valid    (q_valid)
    );

    // sorter and trimmed mean
    swtm_back #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .pop_entry    (pop_entry),
        .pop          (pop),
        .scale_enable (scale_enable_reg),
        .gain_q16     (gain_q16_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

/* rtl/swtm_front.sv */
module swtm_front #(
    parameter int SAMPLE_COUNT = swtm_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [swtm_pkg::TDATA_W-1:0] s_tdata,
    output logic                         push,
    output swtm_pkg::entry_t             push_entry,
    input  logic                         q_ready
);

    localparam int CW = $clog2(SAMPLE_COUNT);
    localparam logic [CW-1:0] LAST_IDX = CW'(SAMPLE_COUNT - 1);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          is_last;

    // word goes straight into the queue, tagged when it closes a block
    assign s_tready          = q_ready;
    assign push              = s_tvalid && q_ready;
    assign is_last           = (cnt_reg == LAST_IDX);
    assign push_entry.sample = s_tdata[swtm_pkg::SAMPLE_W-1:0];
    assign push_entry.last   = is_last;

    always_comb begin
        cnt_next = cnt_reg;
        if (push) begin
            cnt_next = is_last ? '0 : cnt_reg + 1'b1;
        end
    end

    // position within the current block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/swtm_fifo.sv */
module swtm_fifo #(
    parameter int DEPTH = swtm_pkg::FIFO_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  swtm_pkg::entry_t push_entry,
    output logic             q_ready,
    input  logic             pop,
    output swtm_pkg::entry_t pop_entry,
    output logic             q_valid
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

    swtm_pkg::entry_t slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    cnt_reg;

    assign q_ready   = (cnt_reg != FULL_CNT);
    assign q_valid   = (cnt_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/swtm_back.sv */
module swtm_back #(
    parameter int SAMPLE_COUNT = swtm_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  swtm_pkg::entry_t             pop_entry,
    output logic                         pop,
    input  logic                         scale_enable,
    input  logic [swtm_pkg::GAIN_W-1:0]  gain_q16,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [swtm_pkg::TDATA_W-1:0] m_tdata
);

    localparam int AW  = $clog2(SAMPLE_COUNT);
    localparam int MID = SAMPLE_COUNT / 2;
    localparam logic [AW-1:0] MID_BASE = AW'(MID - 1);
    localparam logic [2:0]    MID_TAPS = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MID,
        ST_AVG,
        ST_EMIT
    } state_t;

    state_t                              state_reg;
    logic [AW-1:0]                       k_reg;
    logic [AW-1:0]                       j_reg;
    logic [2:0]                          m_reg;
    logic [swtm_pkg::SAMPLE_W-1:0]       val_reg;
    logic                                last_reg;
    logic [swtm_pkg::SUM_W-1:0]          sum_reg;
    logic [swtm_pkg::SAMPLE_W-1:0]       avg_reg;
    logic [swtm_pkg::PROD_W-1:0]         prod_reg;
    logic                                m_tvalid_reg;
    logic [swtm_pkg::SAMPLE_W-1:0]       m_data_reg;

    // sorted block store, one write and one registered read per cycle
    logic [swtm_pkg::SAMPLE_W-1:0]       mem [SAMPLE_COUNT];
    logic [swtm_pkg::SAMPLE_W-1:0]       rd_data_reg;
    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    logic [AW-1:0]                       mem_raddr;
    logic [swtm_pkg::SAMPLE_W-1:0]       mem_wdata;

    logic                                scan_stop;
    logic                                out_free;
    logic [swtm_pkg::SAMPLE_W-1:0]       result;

    assign scan_stop = (j_reg == '0) || (rd_data_reg <= val_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign result    = scale_enable ? prod_reg[swtm_pkg::PROD_W-1:swtm_pkg::GAIN_W] : avg_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(swtm_pkg::TDATA_W - swtm_pkg::SAMPLE_W){1'b0}}, m_data_reg};

    // memory addressing and queue pop
    always_comb begin
        pop       = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = j_reg;
        mem_wdata = val_reg;
        mem_raddr = j_reg - AW'(2);
        unique case (state_reg)
            ST_IDLE: begin
                pop       = q_valid;
                mem_raddr = k_reg - 1'b1;
            end
            ST_SCAN: begin
                // shift the larger entry up, or drop the new word into its slot
                mem_we    = 1'b1;
                mem_wdata = scan_stop ? val_reg : rd_data_reg;
            end
            ST_MID: begin
                mem_raddr = MID_BASE + AW'(m_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // insertion sequencer, middle sum, gain and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // output valid: set on emit, cleared once taken
            if ((state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        val_reg   <= pop_entry.sample;
                        last_reg  <= pop_entry.last;
                        j_reg     <= k_reg;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_stop) begin
                        if (last_reg) begin
                            k_reg     <= '0;
                            m_reg     <= '0;
                            sum_reg   <= '0;
                            state_reg <= ST_MID;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        j_reg <= j_reg - 1'b1;
                    end
                end
                ST_MID: begin
                    // read data is registered, so it belongs to the previous address
                    if (m_reg != '0) begin
                        sum_reg <= sum_reg + swtm_pkg::SUM_W'(rd_data_reg);
                    end
                    m_reg <= m_reg + 1'b1;
                    if (m_reg == MID_TAPS) begin
                        state_reg <= ST_AVG;
                    end
                end
                ST_AVG: begin
                    avg_reg   <= sum_reg[swtm_pkg::SUM_W-1:2];
                    prod_reg  <= swtm_pkg::PROD_W'(sum_reg[swtm_pkg::SUM_W-1:2])
                                 * swtm_pkg::PROD_W'(gain_q16);
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_data_reg   <= result;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/swtm_checker.sv */
`include "sorted_window_trimmed_mean_top_assert.svh"

module swtm_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [swtm_pkg::TDATA_W-1:0] m_tdata
);

    // a held word stays offered
    `SWTM_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid)

    // a held word keeps its value
    `SWTM_ASSERT_NEXT(a_out_stable, aclk, !aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    // padding above the result stays zero
    `SWTM_ASSERT_IMPLY(a_out_pad, aclk, !aresetn, m_tvalid, m_tdata[15:12] == 4'd0)

    // reset drops any pending result
    `SWTM_ASSERT_NEXT(a_reset_clear, aclk, 1'b0, !aresetn, !m_tvalid)

endmodule

bind sorted_window_trimmed_mean_top swtm_checker u_swtm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN          = swtm_pkg::SAMPLE_COUNT_DEF;
    localparam int SETTLE_CYC   = (swtm_pkg::FIFO_DEPTH_DEF + 2) * (WIN + 2) + 30;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYC     = 400;

    // indexes the block does not decode
    localparam logic [swtm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [swtm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [swtm_pkg::TDATA_W-1:0]    s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [swtm_pkg::TDATA_W-1:0]    m_tdata;
    logic                            cfg_wen;
    logic [swtm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [swtm_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // predictor state
    logic [swtm_pkg::SAMPLE_W-1:0] window_buf [WIN];
    int                            window_fill;
    logic                          scale_on;
    logic [swtm_pkg::GAIN_W-1:0]   gain_reg;
    logic [swtm_pkg::SAMPLE_W-1:0] mean_q [$];

    // run bookkeeping
    int          fails;
    int          samples_sent;
    int          blocks_checked;
    int          cfg_writes;
    int          quiet_cycles;
    logic [swtm_pkg::SAMPLE_W-1:0] exp_mean;
    logic [swtm_pkg::SAMPLE_W-1:0] last_sample;
    logic [swtm_pkg::SAMPLE_W-1:0] cluster_base;

    // idling controls
    bit          tx_gaps_on;
    bit          rx_gaps_on;
    bit          hold_start;
    bit          hold_done;
    int          hold_left;
    int          stall_left;
    int          rx_roll;

    sorted_window_trimmed_mean_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // sorted middle four of the block, averaged and optionally scaled
    function automatic logic [swtm_pkg::SAMPLE_W-1:0] trimmed_mean();
        int unsigned vals [$];
        int unsigned sum;
        int unsigned avg;
        int          mid;
        for (int i = 0; i < WIN; i++) vals.push_back(int'(window_buf[i]));
        vals.sort();
        mid = WIN / 2;
        sum = vals[mid-1] + vals[mid] + vals[mid+1] + vals[mid+2];
        avg = sum >> 2;
        if (scale_on) avg = (avg * int'(gain_reg)) >> 16;
        return avg[swtm_pkg::SAMPLE_W-1:0];
    endfunction

    // one accepted word into the block window
    function automatic void absorb_sample(logic [swtm_pkg::TDATA_W-1:0] word);
        window_buf[window_fill] = word[swtm_pkg::SAMPLE_W-1:0];
        window_fill++;
        if (window_fill == WIN) begin
            window_fill = 0;
            mean_q.push_back(trimmed_mean());
        end
    endfunction

    // random sample word, pad bits random too
    function automatic logic [swtm_pkg::TDATA_W-1:0] rand_word();
        int unsigned                   mode;
        logic [swtm_pkg::SAMPLE_W-1:0] v;
        logic [3:0]                    pad;
        mode = $urandom_range(0, 9);
        pad  = 4'($urandom_range(0, 15));
        if (mode < 5) begin
            v = swtm_pkg::SAMPLE_W'($urandom_range(0, 4095));
        end else if (mode == 5) begin
            v = $urandom_range(0, 1) ? swtm_pkg::SAMPLE_W'(4095 - $urandom_range(0, 3))
                                     : swtm_pkg::SAMPLE_W'($urandom_range(0, 3));
        end else if (mode < 8) begin
            v = cluster_base + swtm_pkg::SAMPLE_W'($urandom_range(0, 31));
            if (v < cluster_base) v = 12'hFFF;
        end else begin
            v = last_sample;
        end
        last_sample = v;
        return {pad, v};
    endfunction

    // offer one word, return once it has been taken
    task automatic send_sample(input logic [swtm_pkg::TDATA_W-1:0] word);
        int unsigned roll;
        int          gap;
        gap = 0;
        if (tx_gaps_on) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)      gap = 0;
            else if (roll < 92) gap = $urandom_range(1, 3);
            else                gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= swtm_pkg::TDATA_W'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        absorb_sample(word);
        samples_sent++;
    endtask

    task automatic send_burst(input int count);
        cluster_base = swtm_pkg::SAMPLE_W'($urandom_range(0, 4095));
        for (int i = 0; i < count; i++) send_sample(rand_word());
    endtask

    // register write, one cycle on the port, then cfg_wen dropped
    task automatic cfg_write(input logic [swtm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swtm_pkg::CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            swtm_pkg::REG_SCALE_ENABLE: scale_on = data[0];
            swtm_pkg::REG_GAIN_Q16:     gain_reg = data[swtm_pkg::GAIN_W-1:0];
            default:                    ;
        endcase
        cfg_writes++;
        cfg_wen   <= 1'b0;
        cfg_wdata <= swtm_pkg::CFG_DATA_W'($urandom);
        @(posedge aclk);
    endtask

    // drain results, then let a partly filled block finish its inserts
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (mean_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // directed block: extremes, ties, pad bits set, descending order
    task automatic test_directed_extremes();
        logic [swtm_pkg::TDATA_W-1:0] words [WIN];
        words = '{16'hFFFF, 16'h0FFF, 16'hAFFF, 16'h0FFF, 16'h5FFF, 16'h0FFF,
                  16'h3FFF, 16'h0FFF, 16'hCFFF, 16'h0800, 16'h07FF, 16'h0001,
                  16'hF000, 16'h0000, 16'h0000, 16'h8000};
        foreach (words[i]) send_sample(words[i]);
        // first half of the next block alternates 0 and 4095
        for (int i = 0; i < 8; i++) send_sample(i[0] ? 16'h0FFF : 16'hF000);
        settle_idle();
    endtask

    task automatic test_raw_average();
        send_burst(200);
        settle_idle();
    endtask

    // scaling turned on by a wide value, gain still at its reset value
    task automatic test_default_gain();
        cfg_write(swtm_pkg::REG_SCALE_ENABLE, 16'hFFFF);
        send_burst(200);
        settle_idle();
    endtask

    task automatic test_full_gain();
        cfg_write(swtm_pkg::REG_GAIN_Q16, 16'hFFFF);
        send_burst(150);
        settle_idle();
    endtask

    task automatic test_zero_gain();
        cfg_write(swtm_pkg::REG_GAIN_Q16, 16'h0000);
        send_burst(100);
        settle_idle();
    endtask

    // writes to undecoded indexes must leave both registers alone
    task automatic test_unknown_index();
        cfg_write(swtm_pkg::REG_GAIN_Q16, swtm_pkg::CFG_DATA_W'($urandom));
        cfg_write(REG_SPARE_A, swtm_pkg::CFG_DATA_W'($urandom));
        cfg_write(REG_SPARE_B, 16'hFFFF);
        cfg_write(REG_SPARE_A, 16'h0000);
        send_burst(150);
        settle_idle();
    endtask

    // scaling off by a wide value with bit 0 clear, no idling on either side
    task automatic test_wide_scale_off();
        cfg_write(swtm_pkg::REG_SCALE_ENABLE, 16'hFFFE);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        send_burst(150);
        settle_idle();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_unit_gain();
        cfg_write(swtm_pkg::REG_SCALE_ENABLE, 16'h0001);
        cfg_write(swtm_pkg::REG_GAIN_Q16, 16'h0001);
        send_burst(100);
        settle_idle();
    endtask

    // receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        cfg_write(swtm_pkg::REG_GAIN_Q16, swtm_pkg::GAIN_RESET);
        hold_start = 1'b1;
        tx_gaps_on = 1'b0;
        send_burst(4 * WIN);
        tx_gaps_on = 1'b1;
        settle_idle();
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < 4; p++) begin
            cfg_write(swtm_pkg::REG_SCALE_ENABLE, swtm_pkg::CFG_DATA_W'($urandom));
            cfg_write(swtm_pkg::REG_GAIN_Q16, swtm_pkg::CFG_DATA_W'($urandom));
            send_burst(80);
            settle_idle();
        end
    endtask

    // receiver side ready pattern
    initial begin
        m_tready   = 1'b0;
        hold_done  = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_start && !hold_done) begin
                hold_left = HOLD_CYC;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!rx_gaps_on) begin
                m_tready <= 1'b1;
            end else begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 70) begin
                    m_tready <= 1'b1;
                end else begin
                    stall_left = (rx_roll < 95) ? $urandom_range(0, 2)
                                                : $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // result check against the oldest expected mean
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (mean_q.size() == 0) begin
                $error("filtered_value: unexpected word, expected none, actual %0d",
                       m_tdata[swtm_pkg::SAMPLE_W-1:0]);
                fails++;
            end else begin
                exp_mean = mean_q.pop_front();
                if (m_tdata[swtm_pkg::SAMPLE_W-1:0] !== exp_mean) begin
                    $error("filtered_value: expected %0d, actual %0d",
                           exp_mean, m_tdata[swtm_pkg::SAMPLE_W-1:0]);
                    fails++;
                end
                blocks_checked++;
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // test sequence
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_wen      = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        fails        = 0;
        samples_sent = 0;
        blocks_checked = 0;
        cfg_writes   = 0;
        quiet_cycles = 0;
        window_fill  = 0;
        scale_on     = 1'b0;
        gain_reg     = swtm_pkg::GAIN_RESET;
        last_sample  = '0;
        cluster_base = '0;
        tx_gaps_on   = 1'b1;
        rx_gaps_on   = 1'b1;
        hold_start   = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_raw_average();
        test_default_gain();
        test_full_gain();
        test_zero_gain();
        test_unknown_index();
        test_wide_scale_off();
        test_unit_gain();
        test_backpressure();
        test_random_mix();

        $display("run: %0d samples in, %0d block means checked, %0d register writes",
                 samples_sent, blocks_checked, cfg_writes);
        $display("run: raw and scaled means, gain 0/1/max/reset, spare indexes, long hold-off");
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
